@@ hdl/countdown_timer_fsm_core_assert.svh @@
// Assertion macros for the countdown timer core.
`ifndef COUNTDOWN_TIMER_FSM_CORE_ASSERT_SVH
`define COUNTDOWN_TIMER_FSM_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CTFSM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check a consequence at the clock edge after the antecedent.
`define CTFSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ctfsm_pkg.sv @@
// Types, codes and constants of the countdown timer core.
`timescale 1ns / 1ps

package ctfsm_pkg;

  localparam int unsigned MAX_SET_SECONDS = 59999;

  localparam int unsigned SET_W   = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned STEP_W  = 12;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 12'd60;
  localparam logic [PHASE_W-1:0] CD_PHASE_RESET = 4'd10;
  localparam logic [PHASE_W-1:0] BEEP_PHASE_RESET = 4'd5;
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd50;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SET   = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_STAT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_INC   = 3'd0,
    CMD_DEC   = 3'd1,
    CMD_SP    = 3'd2,
    CMD_ABORT = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    SCR_NONE     = 3'd0,
    SCR_IDLE     = 3'd1,
    SCR_TIME     = 3'd2,
    SCR_CLR_TIME = 3'd3,
    SCR_PAUSED   = 3'd4,
    SCR_STAT     = 3'd5,
    SCR_CLR      = 3'd6
  } screen_e;

  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_HANDLED = 2'd1,
    OUT_TRANS   = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SECONDS    = 2'd0,
    CFG_COUNTDOWN_PHASE = 2'd1,
    CFG_BEEP_PHASE      = 2'd2,
    CFG_STAT_HOLD_TICKS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [PHASE_W-1:0] tick_phase;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [TOTAL_W-1:0] shown_seconds;
    logic [2:0]         screen;
    logic               beep;
    logic [1:0]         outcome;
  } out_item_t;

endpackage

@@ hdl/countdown_timer_fsm_core.sv @@
// Top level of the countdown timer core: input register, mode logic, result register.
`timescale 1ns / 1ps

// Countdown timer with idle, time set, countdown, paused and statistics modes. Each input item
// is one button event or one tick; each gives exactly one result item with the new mode, a
// screen code, the shown time, a beep flag and the outcome. One item is taken every clock cycle
// unless back-pressure holds the result register. An accepted item passes through the input
// register and then the result register, with the whole mode update done in one pass between
// them. The configuration port is always ready; write it only while no item is in flight.
module countdown_timer_fsm_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ctfsm_pkg::in_item_t      in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ctfsm_pkg::out_item_t     out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ctfsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ctfsm_pkg::STEP_W-1:0]    cfg_data_i
);

  `include "countdown_timer_fsm_core_assert.svh"

  localparam int unsigned SumW = ctfsm_pkg::SET_W + 1;
  localparam logic [SumW-1:0] MaxSet = SumW'(ctfsm_pkg::MAX_SET_SECONDS);

  logic [ctfsm_pkg::STEP_W-1:0]  step_q;
  logic [ctfsm_pkg::PHASE_W-1:0] cd_phase_q;
  logic [ctfsm_pkg::PHASE_W-1:0] beep_phase_q;
  logic [ctfsm_pkg::HOLD_W-1:0]  hold_q;

  logic                 s1_valid_q;
  ctfsm_pkg::in_item_t  s1_item_q;
  logic                 out_valid_q;
  ctfsm_pkg::out_item_t out_item_q, out_item_d;
  logic                 advance;

  ctfsm_pkg::mode_e                mode_q, mode_d;
  logic [ctfsm_pkg::SET_W-1:0]     set_q, set_d;
  logic [ctfsm_pkg::SET_W-1:0]     elapsed_q, elapsed_d;
  logic [ctfsm_pkg::TOTAL_W-1:0]   total_q, total_d;
  logic [ctfsm_pkg::HOLD_W-1:0]    stat_cnt_q, stat_cnt_d;

  logic [SumW-1:0]                 inc_sum;
  logic                            inc_ok;
  logic                            dec_ok;
  logic [ctfsm_pkg::SET_W-1:0]     dec_val;
  logic [ctfsm_pkg::SET_W-1:0]     run_set;
  logic [ctfsm_pkg::SET_W-1:0]     run_elapsed;
  logic [ctfsm_pkg::SET_W-1:0]     leave_elapsed;
  logic [ctfsm_pkg::TOTAL_W:0]     total_sum;
  logic [ctfsm_pkg::TOTAL_W-1:0]   total_leave;
  logic [ctfsm_pkg::HOLD_W-1:0]    stat_inc;
  logic                            is_tick;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ctfsm_pkg::STEP_RESET;
      cd_phase_q   <= ctfsm_pkg::CD_PHASE_RESET;
      beep_phase_q <= ctfsm_pkg::BEEP_PHASE_RESET;
      hold_q       <= ctfsm_pkg::HOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ctfsm_pkg::CFG_STEP_SECONDS:    step_q       <= cfg_data_i;
        ctfsm_pkg::CFG_COUNTDOWN_PHASE: cd_phase_q   <= cfg_data_i[ctfsm_pkg::PHASE_W-1:0];
        ctfsm_pkg::CFG_BEEP_PHASE:      beep_phase_q <= cfg_data_i[ctfsm_pkg::PHASE_W-1:0];
        ctfsm_pkg::CFG_STAT_HOLD_TICKS: hold_q       <= cfg_data_i[ctfsm_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  // Shared datapath terms
  assign inc_sum  = {1'b0, set_q} + SumW'(step_q);
  assign inc_ok   = (inc_sum <= MaxSet);
  assign dec_ok   = (set_q >= ctfsm_pkg::SET_W'(step_q));
  assign dec_val  = set_q - ctfsm_pkg::SET_W'(step_q);
  assign run_set  = (set_q != '0) ? set_q - 1'b1 : set_q;
  assign run_elapsed = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign is_tick  = (s1_item_q.command == ctfsm_pkg::CMD_TICK);
  assign leave_elapsed = is_tick ? run_elapsed : elapsed_q;
  assign total_sum = {1'b0, total_q} + (ctfsm_pkg::TOTAL_W + 1)'(leave_elapsed);
  assign total_leave = total_sum[ctfsm_pkg::TOTAL_W] ? '1
                                                     : total_sum[ctfsm_pkg::TOTAL_W-1:0];
  assign stat_inc = stat_cnt_q + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    set_d      = set_q;
    elapsed_d  = elapsed_q;
    total_d    = total_q;
    stat_cnt_d = stat_cnt_q;
    out_item_d.shown_seconds = '0;
    out_item_d.screen  = ctfsm_pkg::SCR_NONE;
    out_item_d.beep    = 1'b0;
    out_item_d.outcome = ctfsm_pkg::OUT_IGNORED;
    case (mode_q)
      ctfsm_pkg::MODE_IDLE: begin
        case (s1_item_q.command)
          ctfsm_pkg::CMD_INC: begin
            if (inc_ok) begin
              set_d = inc_sum[ctfsm_pkg::SET_W-1:0];
            end
            mode_d = ctfsm_pkg::MODE_SET;
            out_item_d.screen  = ctfsm_pkg::SCR_CLR_TIME;
            out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(set_d);
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          ctfsm_pkg::CMD_SP: begin
            mode_d     = ctfsm_pkg::MODE_STAT;
            stat_cnt_d = '0;
            out_item_d.screen  = ctfsm_pkg::SCR_STAT;
            out_item_d.shown_seconds = total_q;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          ctfsm_pkg::CMD_TICK: begin
            if (s1_item_q.tick_phase == beep_phase_q) begin
              out_item_d.beep    = 1'b1;
              out_item_d.outcome = ctfsm_pkg::OUT_HANDLED;
            end
          end
          default: ;
        endcase
      end
      ctfsm_pkg::MODE_SET: begin
        case (s1_item_q.command)
          ctfsm_pkg::CMD_INC: begin
            if (inc_ok) begin
              set_d = inc_sum[ctfsm_pkg::SET_W-1:0];
              out_item_d.screen  = ctfsm_pkg::SCR_TIME;
              out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(set_d);
              out_item_d.outcome = ctfsm_pkg::OUT_HANDLED;
            end
          end
          ctfsm_pkg::CMD_DEC: begin
            if (dec_ok) begin
              set_d = dec_val;
              out_item_d.screen  = ctfsm_pkg::SCR_TIME;
              out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(dec_val);
              out_item_d.outcome = ctfsm_pkg::OUT_HANDLED;
            end
          end
          ctfsm_pkg::CMD_SP: begin
            if (dec_ok) begin
              mode_d = ctfsm_pkg::MODE_RUN;
              out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
            end
          end
          ctfsm_pkg::CMD_ABORT: begin
            mode_d    = ctfsm_pkg::MODE_IDLE;
            set_d     = '0;
            elapsed_d = '0;
            out_item_d.screen  = ctfsm_pkg::SCR_IDLE;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          default: ;
        endcase
      end
      ctfsm_pkg::MODE_RUN: begin
        case (s1_item_q.command)
          ctfsm_pkg::CMD_TICK: begin
            if (s1_item_q.tick_phase == cd_phase_q) begin
              set_d = run_set;
              out_item_d.screen = ctfsm_pkg::SCR_TIME;
              out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(run_set);
              if (run_set == '0) begin
                total_d   = total_leave;
                elapsed_d = '0;
                mode_d    = ctfsm_pkg::MODE_SET;
                out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
              end else begin
                elapsed_d = run_elapsed;
                out_item_d.outcome = ctfsm_pkg::OUT_HANDLED;
              end
            end
          end
          ctfsm_pkg::CMD_SP: begin
            total_d   = total_leave;
            elapsed_d = '0;
            mode_d    = ctfsm_pkg::MODE_PAUSE;
            out_item_d.screen  = ctfsm_pkg::SCR_PAUSED;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          ctfsm_pkg::CMD_ABORT: begin
            total_d   = total_leave;
            elapsed_d = '0;
            set_d     = '0;
            mode_d    = ctfsm_pkg::MODE_IDLE;
            out_item_d.screen  = ctfsm_pkg::SCR_IDLE;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          default: ;
        endcase
      end
      ctfsm_pkg::MODE_PAUSE: begin
        case (s1_item_q.command)
          ctfsm_pkg::CMD_INC: begin
            if (inc_ok) begin
              set_d = inc_sum[ctfsm_pkg::SET_W-1:0];
            end
            mode_d = ctfsm_pkg::MODE_SET;
            out_item_d.screen  = ctfsm_pkg::SCR_CLR_TIME;
            out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(set_d);
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          ctfsm_pkg::CMD_DEC: begin
            if (dec_ok) begin
              set_d  = dec_val;
              mode_d = ctfsm_pkg::MODE_SET;
              out_item_d.screen  = ctfsm_pkg::SCR_CLR_TIME;
              out_item_d.shown_seconds = ctfsm_pkg::TOTAL_W'(dec_val);
              out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
            end
          end
          ctfsm_pkg::CMD_SP: begin
            mode_d = ctfsm_pkg::MODE_RUN;
            out_item_d.screen  = ctfsm_pkg::SCR_CLR;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          ctfsm_pkg::CMD_ABORT: begin
            mode_d    = ctfsm_pkg::MODE_IDLE;
            set_d     = '0;
            elapsed_d = '0;
            out_item_d.screen  = ctfsm_pkg::SCR_IDLE;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
          default: ;
        endcase
      end
      default: begin
        if (is_tick) begin
          stat_cnt_d = stat_inc;
          if (stat_inc >= hold_q) begin
            stat_cnt_d = '0;
            mode_d     = ctfsm_pkg::MODE_IDLE;
            set_d      = '0;
            elapsed_d  = '0;
            out_item_d.screen  = ctfsm_pkg::SCR_IDLE;
            out_item_d.outcome = ctfsm_pkg::OUT_TRANS;
          end
        end
      end
    endcase
    out_item_d.mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ctfsm_pkg::MODE_IDLE;
      set_q      <= '0;
      elapsed_q  <= '0;
      total_q    <= '0;
      stat_cnt_q <= '0;
    end else if (advance) begin
      mode_q     <= mode_d;
      set_q      <= set_d;
      elapsed_q  <= elapsed_d;
      total_q    <= total_d;
      stat_cnt_q <= stat_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CTFSM_ASSERT_NEXT(a_no_result_from_nothing, !s1_valid_q && !out_valid_q, !out_valid_q,
    "result register loaded without an item in the input stage")
  `CTFSM_ASSERT_ALWAYS(a_set_in_range, set_q <= ctfsm_pkg::SET_W'(ctfsm_pkg::MAX_SET_SECONDS),
    "set time above its limit")
  `CTFSM_ASSERT_NEXT(a_total_monotonic, 1'b1, total_q >= $past(total_q),
    "total productive time decreased")
  `CTFSM_ASSERT_ALWAYS(a_idle_cleared,
    mode_q != ctfsm_pkg::MODE_IDLE || (set_q == '0 && elapsed_q == '0),
    "idle mode with a nonzero set or elapsed time")

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the countdown timer core with a mode-tracking scoreboard.
`timescale 1ns / 1ps

module tb;
  import ctfsm_pkg::*;

  localparam int ITEMS_PER_SETTING = 165;
  localparam int SETTING_COUNT     = 10;
  localparam int STALL_LIMIT       = 2000;
  localparam int LONG_HOLD         = 300;
  localparam int DRAIN_CYCLES      = 10;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] cd_phase;
    logic [PHASE_W-1:0] beep_phase;
    logic [HOLD_W-1:0]  hold;
  } setting_t;

  class countdown_tracker;
    mode_e               mode;
    logic [SET_W-1:0]    set_secs;
    logic [SET_W-1:0]    elapsed;
    logic [TOTAL_W-1:0]  total;
    logic [HOLD_W-1:0]   stat_ticks;
    logic [STEP_W-1:0]   step;
    logic [PHASE_W-1:0]  cd_phase;
    logic [PHASE_W-1:0]  beep_ph;
    logic [HOLD_W-1:0]   hold;
    out_item_t           pending_results[$];
    int                  errors;
    int                  sent_items;

    function new();
      mode = MODE_IDLE;
      set_secs = '0;
      elapsed = '0;
      total = '0;
      stat_ticks = '0;
      step = STEP_RESET;
      cd_phase = CD_PHASE_RESET;
      beep_ph = BEEP_PHASE_RESET;
      hold = HOLD_RESET;
      errors = 0;
      sent_items = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [STEP_W-1:0] data);
      case (idx)
        CFG_STEP_SECONDS:    step = data;
        CFG_COUNTDOWN_PHASE: cd_phase = data[PHASE_W-1:0];
        CFG_BEEP_PHASE:      beep_ph = data[PHASE_W-1:0];
        CFG_STAT_HOLD_TICKS: hold = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit add_step();
      int unsigned sum;
      sum = set_secs + step;
      if (sum > MAX_SET_SECONDS) return 1'b0;
      set_secs = sum[SET_W-1:0];
      return 1'b1;
    endfunction

    function void end_countdown();
      logic [63:0] sum;
      sum = 64'(total) + 64'(elapsed);
      total = (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
      elapsed = '0;
    endfunction

    function void go_idle();
      mode = MODE_IDLE;
      set_secs = '0;
      elapsed = '0;
    endfunction

    function void apply_event(in_item_t ev);
      out_item_t          r;
      screen_e            scr;
      logic [TOTAL_W-1:0] shown;
      logic               beep;
      outcome_e           res;
      scr = SCR_NONE;
      shown = '0;
      beep = 1'b0;
      res = OUT_IGNORED;
      case (mode)
        MODE_IDLE: begin
          if (ev.command == CMD_INC) begin
            void'(add_step());
            mode = MODE_SET;
            scr = SCR_CLR_TIME; shown = set_secs; res = OUT_TRANS;
          end else if (ev.command == CMD_SP) begin
            mode = MODE_STAT;
            stat_ticks = '0;
            scr = SCR_STAT; shown = total; res = OUT_TRANS;
          end else if (ev.command == CMD_TICK && ev.tick_phase == beep_ph) begin
            beep = 1'b1; res = OUT_HANDLED;
          end
        end
        MODE_SET: begin
          if (ev.command == CMD_INC) begin
            if (add_step()) begin
              scr = SCR_TIME; shown = set_secs; res = OUT_HANDLED;
            end
          end else if (ev.command == CMD_DEC) begin
            if (set_secs >= step) begin
              set_secs = set_secs - step;
              scr = SCR_TIME; shown = set_secs; res = OUT_HANDLED;
            end
          end else if (ev.command == CMD_SP) begin
            if (set_secs >= step) begin
              mode = MODE_RUN; res = OUT_TRANS;
            end
          end else if (ev.command == CMD_ABORT) begin
            go_idle();
            scr = SCR_IDLE; res = OUT_TRANS;
          end
        end
        MODE_RUN: begin
          if (ev.command == CMD_TICK) begin
            if (ev.tick_phase == cd_phase) begin
              if (set_secs != '0) set_secs = set_secs - 1'b1;
              if (elapsed != '1) elapsed = elapsed + 1'b1;
              scr = SCR_TIME; shown = set_secs;
              if (set_secs == '0) begin
                end_countdown();
                mode = MODE_SET;
                res = OUT_TRANS;
              end else begin
                res = OUT_HANDLED;
              end
            end
          end else if (ev.command == CMD_SP) begin
            end_countdown();
            mode = MODE_PAUSE;
            scr = SCR_PAUSED; res = OUT_TRANS;
          end else if (ev.command == CMD_ABORT) begin
            end_countdown();
            go_idle();
            scr = SCR_IDLE; res = OUT_TRANS;
          end
        end
        MODE_PAUSE: begin
          if (ev.command == CMD_INC) begin
            void'(add_step());
            mode = MODE_SET;
            scr = SCR_CLR_TIME; shown = set_secs; res = OUT_TRANS;
          end else if (ev.command == CMD_DEC) begin
            if (set_secs >= step) begin
              set_secs = set_secs - step;
              mode = MODE_SET;
              scr = SCR_CLR_TIME; shown = set_secs; res = OUT_TRANS;
            end
          end else if (ev.command == CMD_SP) begin
            mode = MODE_RUN;
            scr = SCR_CLR; res = OUT_TRANS;
          end else if (ev.command == CMD_ABORT) begin
            go_idle();
            scr = SCR_IDLE; res = OUT_TRANS;
          end
        end
        MODE_STAT: begin
          if (ev.command == CMD_TICK) begin
            stat_ticks = stat_ticks + 1'b1;
            if (stat_ticks >= hold) begin
              stat_ticks = '0;
              go_idle();
              scr = SCR_IDLE; res = OUT_TRANS;
            end
          end
        end
        default: ;
      endcase
      r.mode = mode;
      r.shown_seconds = shown;
      r.screen = scr;
      r.beep = beep;
      r.outcome = res;
      pending_results.push_back(r);
      sent_items++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: mode %0d screen %0d", got.mode, got.screen);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("mode", want.mode, got.mode);
      compare_field("shown_seconds", want.shown_seconds, got.shown_seconds);
      compare_field("screen", want.screen, got.screen);
      compare_field("beep", want.beep, got.beep);
      compare_field("outcome", want.outcome, got.outcome);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data = '0;
  bit                   steady = 1'b0;

  countdown_tracker tracker = new();

  countdown_timer_fsm_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_item_t pack_event(logic [2:0] cmd, logic [PHASE_W-1:0] phase);
    in_item_t ev;
    ev.command = cmd;
    ev.tick_phase = phase;
    return ev;
  endfunction

  function automatic logic [PHASE_W-1:0] any_phase();
    return PHASE_W'($urandom_range(0, 15));
  endfunction

  function automatic in_item_t noise_event();
    return pack_event(3'($urandom_range(0, 7)), any_phase());
  endfunction

  function automatic in_item_t next_event();
    int r;
    bit big;
    r = $urandom_range(0, 99);
    big = tracker.step >= 12'd1024;
    case (tracker.mode)
      MODE_IDLE: begin
        if (r < 40) return pack_event(CMD_INC, any_phase());
        if (r < 55) return pack_event(CMD_SP, any_phase());
        if (r < 70) return pack_event(CMD_TICK, tracker.beep_ph);
        if (r < 85) return pack_event(CMD_TICK, any_phase());
      end
      MODE_SET: begin
        if (big) begin
          if (r < 80) return pack_event(CMD_INC, any_phase());
          if (r < 85) return pack_event(CMD_DEC, any_phase());
          if (r < 92) return pack_event(CMD_SP, any_phase());
          if (r < 95) return pack_event(CMD_ABORT, any_phase());
        end else begin
          if (r < 40) return pack_event(CMD_INC, any_phase());
          if (r < 55) return pack_event(CMD_DEC, any_phase());
          if (r < 85) return pack_event(CMD_SP, any_phase());
          if (r < 90) return pack_event(CMD_ABORT, any_phase());
        end
      end
      MODE_RUN: begin
        if (r < 75) return pack_event(CMD_TICK, tracker.cd_phase);
        if (r < 83) return pack_event(CMD_TICK, any_phase());
        if (r < 91) return pack_event(CMD_SP, any_phase());
        if (r < 94) return pack_event(CMD_ABORT, any_phase());
      end
      MODE_PAUSE: begin
        if (r < 40) return pack_event(CMD_SP, any_phase());
        if (r < 60) return pack_event(CMD_INC, any_phase());
        if (r < 80) return pack_event(CMD_DEC, any_phase());
        if (r < 90) return pack_event(CMD_ABORT, any_phase());
      end
      default: begin
        if (r < 80) return pack_event(CMD_TICK, any_phase());
      end
    endcase
    return noise_event();
  endfunction

  task automatic send_item(in_item_t ev);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (!in_ready);
    tracker.apply_event(ev);
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [PHASE_W-1:0] phase);
    send_item(pack_event(cmd, phase));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
  endtask

  task automatic run_directed();
    send_cmd(CMD_TICK, tracker.beep_ph);
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_DEC, 4'd15);
    send_cmd(CMD_ABORT, 4'd0);
    send_cmd(CMD_SPARE_FIRST, 4'd15);
    send_cmd(CMD_SPARE_FIRST + 3'd1, 4'd0);
    send_cmd(CMD_SPARE_LAST, 4'd15);
    send_cmd(CMD_INC, 4'd0);
    send_cmd(CMD_DEC, 4'd0);
    send_cmd(CMD_DEC, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_INC, 4'd0);
    send_cmd(CMD_INC, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_TICK, tracker.cd_phase);
    send_cmd(CMD_TICK, 4'd15);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_DEC, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_ABORT, 4'd0);
    send_cmd(CMD_SP, 4'd0);
    send_cmd(CMD_TICK, 4'd3);
    send_cmd(CMD_ABORT, 4'd0);
  endtask

  initial begin : result_sink
    int gap;
    int results_seen;
    gap = 0;
    results_seen = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_result(out_item);
        results_seen++;
        if (results_seen == 400 || results_seen == 2000) gap = LONG_HOLD;
        else gap = steady ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("countdown_timer_fsm_core: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    setting_t plan [SETTING_COUNT];
    int idx;
    int target;
    plan[0] = '{STEP_RESET, CD_PHASE_RESET, BEEP_PHASE_RESET, HOLD_RESET};
    plan[1] = '{12'd1, 4'd0, 4'd15, 8'd1};
    plan[2] = '{12'd3600, 4'd15, 4'd0, 8'd255};
    plan[3] = '{12'd0, 4'd7, 4'd7, 8'd0};
    plan[4] = '{12'd4095, 4'd3, 4'd12, 8'd3};
    for (idx = 5; idx < SETTING_COUNT; idx++) begin
      plan[idx] = '{12'($urandom_range(1, 12)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 8'($urandom_range(1, 20))};
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (idx = 0; idx < SETTING_COUNT; idx++) begin
      if (idx > 0) begin
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        write_reg(CFG_STEP_SECONDS, plan[idx].step);
        write_reg(CFG_COUNTDOWN_PHASE, STEP_W'(plan[idx].cd_phase));
        write_reg(CFG_BEEP_PHASE, STEP_W'(plan[idx].beep_phase));
        write_reg(CFG_STAT_HOLD_TICKS, STEP_W'(plan[idx].hold));
        cfg_valid <= 1'b0;
      end
      steady = (idx % 4 == 3);
      target = tracker.sent_items + ITEMS_PER_SETTING;
      while (tracker.sent_items < target) send_item(next_event());
    end
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("countdown_timer_fsm_core: match");
    end else begin
      $display("countdown_timer_fsm_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ctfsm_pkg.sv
hdl/countdown_timer_fsm_core.sv
bench/tb.sv
